/* hdl/pva_pkg.sv */
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and constants for the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;
  localparam int NUM_SLOTS = 32;
  localparam int SLOT_W    = 5;
  localparam int Q_DEPTH   = 2;
  localparam logic [31:0] ONE_Q31     = 32'h8000_0000;
  localparam logic [31:0] THRESH_RST  = 32'd215;

  typedef enum logic [2:0] {
    FN_NOTE_ON  = 3'd0,
    FN_NOTE_OFF = 3'd1,
    FN_PEDAL    = 3'd2,
    FN_LEVEL    = 3'd3,
    FN_PANIC    = 3'd4
  } func_t;

  localparam logic [1:0] ACT_STRIKE  = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_RETIRE  = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic        down;
    logic [4:0]  sidx;
    logic [31:0] peak;
    logic        hdone;
  } cmd_t;
endpackage

/* hdl/pva_front.sv */
// ----------------------------------------------------------------------------
// pva_front
// Accepts commands, drops unknown ones, queues the rest for the engine.
// ----------------------------------------------------------------------------
module pva_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  pva_pkg::cmd_t  cmd_in,
  output logic           busy,
  output logic           q_valid,
  output pva_pkg::cmd_t  q_cmd,
  input  logic           q_pop,
  output logic           q_empty_idle
);
  pva_pkg::cmd_t q_mem_r [pva_pkg::Q_DEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push;

  // unknown function codes are swallowed here
  assign busy  = (cnt_r == 2'(pva_pkg::Q_DEPTH));
  assign push  = start && !busy && (cmd_in.func <= 3'(pva_pkg::FN_PANIC));
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = q_mem_r[rp_r];
  assign q_empty_idle = (cnt_r == 2'd0);

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
    if (push) q_mem_r[wp_r] <= cmd_in;
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0) else $error("pop of empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(pva_pkg::Q_DEPTH)) else $error("queue overflow");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("count slip");
endmodule

/* hdl/pva_engine.sv */
// ----------------------------------------------------------------------------
// pva_engine
// Slot table and sequencer; scans slots one per cycle.
// ----------------------------------------------------------------------------
module pva_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  pva_pkg::cmd_t  q_cmd,
  output logic           q_pop,
  input  logic [31:0]    thresh,
  output logic           eng_idle,
  output logic           out_valid,
  output logic [1:0]     action,
  output logic [4:0]     out_slot,
  output logic [6:0]     out_note,
  output logic [6:0]     out_velocity,
  output logic           stolen,
  output logic           last
);
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_LVL, S_DIV, S_LVL2, S_EMIT
  } state_t;

  localparam int SW = pva_pkg::SLOT_W;

  logic [pva_pkg::NUM_SLOTS-1:0] used_r, held_r, sus_r;
  logic [6:0]  note_r  [pva_pkg::NUM_SLOTS];
  logic [31:0] level_r [pva_pkg::NUM_SLOTS];
  logic        pedal_r;

  state_t      st_r;
  pva_pkg::cmd_t c_r;
  logic [SW:0] idx_r;
  logic [32:0] best_r;
  logic [SW-1:0] steal_r;
  logic        have_r;
  logic        pend_r;          // a found result waits to be shown
  logic [SW-1:0] pslot_r;
  logic [6:0]  pnote_r;
  logic [1:0]  pact_r;
  logic [31:0] lv_r, pk_r;
  logic [36:0] num_r;
  logic [43:0] acc_r;

  logic [SW-1:0] i;
  logic [32:0]   lcur;
  logic          match;
  logic [36:0]   num;
  logic [31:0]   quo;
  logic [34:0]   q1;

  assign i    = idx_r[SW-1:0];
  assign lcur = {1'b0, level_r[i]} + (held_r[i] ? 33'(pva_pkg::ONE_Q31) : 33'd0);
  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign eng_idle = (st_r == S_IDLE) && !pend_r;

  always_comb begin
    match = 1'b0;
    case (c_r.func)
      3'(pva_pkg::FN_NOTE_OFF): match = used_r[i] && held_r[i] && note_r[i] == c_r.note;
      3'(pva_pkg::FN_PEDAL):    match = used_r[i] && sus_r[i] && !held_r[i];
      default:                  match = 1'b0;
    endcase
  end

  // n/20 = (n/4)/5; 1/5 = 3/16 * (1+2^-4)(1+2^-8)(1+2^-16)(1+2^-32), one
  // shift-add per cycle with 8 guard bits, then a single +1 correction
  assign num = 37'(17) * 37'(lv_r) + 37'(3) * 37'(pk_r);
  assign q1  = 35'(acc_r[43:12]) + 35'd1;
  always_comb begin
    quo = acc_r[43:12];
    if (({q1[32:0], 2'b00} + q1) <= num_r[36:2]) quo = q1[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; used_r <= '0; held_r <= '0; sus_r <= '0; pedal_r <= 1'b0;
      pend_r <= 1'b0; out_valid <= 1'b0; idx_r <= '0; have_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (st_r)
        S_IDLE: if (q_valid) begin
          c_r <= q_cmd; idx_r <= '0; have_r <= 1'b0; pend_r <= 1'b0;
          case (q_cmd.func)
            3'(pva_pkg::FN_NOTE_ON), 3'(pva_pkg::FN_NOTE_OFF): st_r <= S_SCAN;
            3'(pva_pkg::FN_PEDAL): begin
              pedal_r <= q_cmd.down;
              if (!q_cmd.down) st_r <= S_SCAN;
            end
            3'(pva_pkg::FN_LEVEL):
              if (32'(q_cmd.sidx) < 32'(pva_pkg::NUM_SLOTS) && used_r[q_cmd.sidx]) begin
                pk_r <= (q_cmd.peak > pva_pkg::ONE_Q31) ? pva_pkg::ONE_Q31 : q_cmd.peak;
                lv_r <= level_r[q_cmd.sidx];
                st_r <= S_LVL;
              end
            default: begin
              used_r <= '0; held_r <= '0; sus_r <= '0; pedal_r <= 1'b0;
              for (int k = 0; k < pva_pkg::NUM_SLOTS; k++) level_r[k] <= '0;
            end
          endcase
        end
        S_SCAN: begin
          if (c_r.func == 3'(pva_pkg::FN_NOTE_ON)) begin
            if (!used_r[i] || idx_r == (SW+1)'(pva_pkg::NUM_SLOTS - 1)) begin
              logic [SW-1:0] p;
              logic stl;
              stl = used_r[i];
              p = i;
              if (used_r[i] && have_r && !(lcur < best_r)) p = steal_r;
              used_r[p] <= 1'b1; held_r[p] <= 1'b1; sus_r[p] <= 1'b0;
              note_r[p] <= c_r.note; level_r[p] <= pva_pkg::ONE_Q31;
              out_valid <= 1'b1; action <= pva_pkg::ACT_STRIKE; out_slot <= p;
              out_note <= c_r.note; out_velocity <= c_r.vel; stolen <= stl; last <= 1'b1;
              st_r <= S_IDLE;
            end else begin
              if (!have_r || lcur < best_r) begin
                best_r <= lcur; steal_r <= i; have_r <= 1'b1;
              end
              idx_r <= idx_r + 1'b1;
            end
          end else begin
            // releases: show a found one once the next is known, so last is exact
            if (match) begin
              if (c_r.func == 3'(pva_pkg::FN_NOTE_OFF)) begin
                held_r[i] <= 1'b0;
                if (pedal_r) sus_r[i] <= 1'b1;
              end else sus_r[i] <= 1'b0;
            end
            if (match && !(c_r.func == 3'(pva_pkg::FN_NOTE_OFF) && pedal_r)) begin
              if (pend_r) begin
                out_valid <= 1'b1; action <= pact_r; out_slot <= pslot_r;
                out_note <= pnote_r; out_velocity <= '0; stolen <= 1'b0; last <= 1'b0;
              end
              pend_r <= 1'b1; pslot_r <= i; pnote_r <= note_r[i];
              pact_r <= pva_pkg::ACT_RELEASE;
            end
            if (idx_r == (SW+1)'(pva_pkg::NUM_SLOTS - 1)) st_r <= S_EMIT;
            else idx_r <= idx_r + 1'b1;
          end
        end
        S_LVL: begin
          num_r <= num;
          st_r  <= S_DIV;
        end
        S_DIV: begin
          case (idx_r[2:0])
            3'd0:    acc_r <= {36'(num_r[36:2]) * 36'd3, 8'd0};
            3'd1:    acc_r <= acc_r + (acc_r >> 4);
            3'd2:    acc_r <= acc_r + (acc_r >> 8);
            3'd3:    acc_r <= acc_r + (acc_r >> 16);
            default: acc_r <= acc_r + (acc_r >> 32);
          endcase
          idx_r <= idx_r + 1'b1;
          if (idx_r[2:0] == 3'd4) st_r <= S_LVL2;
        end
        S_LVL2: begin
          logic [31:0] nl;
          nl = (pk_r > lv_r) ? pk_r : quo;
          level_r[c_r.sidx] <= nl;
          if (c_r.hdone && nl < thresh) begin
            used_r[c_r.sidx] <= 1'b0;
            out_valid <= 1'b1; action <= pva_pkg::ACT_RETIRE; out_slot <= c_r.sidx;
            out_note <= note_r[c_r.sidx]; out_velocity <= '0; stolen <= 1'b0;
            last <= 1'b1;
          end
          st_r <= S_IDLE;
        end
        S_EMIT: begin
          if (pend_r) begin
            out_valid <= 1'b1; action <= pact_r; out_slot <= pslot_r;
            out_note <= pnote_r; out_velocity <= '0; stolen <= 1'b0; last <= 1'b1;
          end
          pend_r <= 1'b0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !pend_r) else $error("pending result at pop");
  a_strike_used: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && action == pva_pkg::ACT_STRIKE) |-> used_r[out_slot])
    else $error("strike slot not used");
  a_retire_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && action == pva_pkg::ACT_RETIRE) |-> !used_r[out_slot])
    else $error("retired slot still used");
endmodule

/* hdl/poly_voice_allocator_core.sv */
// ----------------------------------------------------------------------------
// poly_voice_allocator_core
// Voice allocator with stealing: command queue front, slot-scan engine back.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; a two-entry queue
// holds commands while the engine works. Note-on, note-off and pedal-up scan
// the slot table one slot per cycle; a level report passes through S_LVL,
// S_DIV and S_LVL2; pedal-down and panic end in S_IDLE. Each result shows
// for one cycle with out_valid, cannot be stalled; last marks the final one.
module poly_voice_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [6:0]  in_note_number,
  input  logic [6:0]  in_velocity,
  input  logic        in_pedal_down,
  input  logic [4:0]  in_slot_index,
  input  logic [31:0] in_block_peak,
  input  logic        in_hammer_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_retire_threshold,
  output logic        out_valid,
  output logic [1:0]  out_action,
  output logic [4:0]  out_slot,
  output logic [6:0]  out_note,
  output logic [6:0]  out_velocity,
  output logic        out_stolen,
  output logic        out_last
);
  pva_pkg::cmd_t cmd, q_cmd;
  logic q_valid, q_pop, q_idle, eng_idle;
  logic [31:0] thresh_r;

  assign cmd = '{func: in_func, note: in_note_number, vel: in_velocity,
                 down: in_pedal_down, sidx: in_slot_index, peak: in_block_peak,
                 hdone: in_hammer_done};
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) thresh_r <= pva_pkg::THRESH_RST;
    else if (cfg_valid) thresh_r <= cfg_retire_threshold;
  end

  pva_front u_front (.clk, .rst_n, .start, .cmd_in(cmd), .busy, .q_valid,
    .q_cmd, .q_pop, .q_empty_idle(q_idle));

  pva_engine u_engine (.clk, .rst_n, .q_valid, .q_cmd, .q_pop, .thresh(thresh_r),
    .eng_idle, .out_valid, .action(out_action), .out_slot, .out_note,
    .out_velocity, .stolen(out_stolen), .last(out_last));

  a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (q_idle && eng_idle) |=> !out_valid || $past(q_pop)) else $error("stray result");
endmodule
